// File: design/uart_registers_with_rx_fifo_core_macros.svh
// assertion macros shared by the uart register block with receive fifo
// expects signals named clock and reset in the module that uses them
`ifndef UART_REGISTERS_WITH_RX_FIFO_CORE_MACROS_SVH
`define UART_REGISTERS_WITH_RX_FIFO_CORE_MACROS_SVH

// same-cycle implication
`define UARTRX_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UARTRX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/uartrx_pkg.sv
// types, register offsets and constants of the uart register block with receive fifo
// no dependencies
`default_nettype none

package uartrx_pkg;

   localparam int RX_DEPTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_PUSH  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // register offsets
   localparam logic [11:0] OFFS_DATA     = 12'h000;
   localparam logic [11:0] OFFS_RX_STAT  = 12'h004;
   localparam logic [11:0] OFFS_FLAGS    = 12'h018;
   localparam logic [11:0] OFFS_BAUD_INT = 12'h024;
   localparam logic [11:0] OFFS_BAUD_FRC = 12'h028;
   localparam logic [11:0] OFFS_LINE_CTL = 12'h02C;
   localparam logic [11:0] OFFS_CONTROL  = 12'h030;
   localparam logic [11:0] OFFS_FIFO_LVL = 12'h034;
   localparam logic [11:0] OFFS_IRQ_MASK = 12'h038;
   localparam logic [11:0] OFFS_IRQ_RAW  = 12'h03C;
   localparam logic [11:0] OFFS_IRQ_MSKD = 12'h040;
   localparam logic [11:0] OFFS_IRQ_CLR  = 12'h044;
   localparam logic [11:0] OFFS_DMA_CTL  = 12'h048;
   localparam logic [11:0] OFFS_PERIPH_ID0 = 12'hFE0;
   localparam logic [11:0] OFFS_PERIPH_ID1 = 12'hFE4;
   localparam logic [11:0] OFFS_PERIPH_ID2 = 12'hFE8;
   localparam logic [11:0] OFFS_PERIPH_ID3 = 12'hFEC;
   localparam logic [11:0] OFFS_CELL_ID0   = 12'hFF0;
   localparam logic [11:0] OFFS_CELL_ID1   = 12'hFF4;
   localparam logic [11:0] OFFS_CELL_ID2   = 12'hFF8;
   localparam logic [11:0] OFFS_CELL_ID3   = 12'hFFC;

   // id words
   localparam logic [31:0] PERIPH_ID0 = 32'h0000_0011;
   localparam logic [31:0] PERIPH_ID1 = 32'h0000_0010;
   localparam logic [31:0] PERIPH_ID2 = 32'h0000_0034;
   localparam logic [31:0] PERIPH_ID3 = 32'h0000_0000;
   localparam logic [31:0] CELL_ID0   = 32'h0000_000D;
   localparam logic [31:0] CELL_ID1   = 32'h0000_00F0;
   localparam logic [31:0] CELL_ID2   = 32'h0000_0005;
   localparam logic [31:0] CELL_ID3   = 32'h0000_00B1;

   localparam logic [5:0] FIFO_LVL_RESET = 6'h12;

   // interrupt and control bits
   localparam int IRQ_RX_BIT   = 4;
   localparam int IRQ_TX_BIT   = 5;
   localparam int CTRL_EN_BIT  = 0;
   localparam int CTRL_TXE_BIT = 8;

   // trigger level selection codes
   localparam logic [2:0] TRIG_SEL_EIGHTH    = 3'd0;
   localparam logic [2:0] TRIG_SEL_QUARTER   = 3'd1;
   localparam logic [2:0] TRIG_SEL_HALF      = 3'd2;
   localparam logic [2:0] TRIG_SEL_3QUARTER  = 3'd3;
   localparam logic [2:0] TRIG_SEL_7EIGHTHS  = 3'd4;

   typedef struct packed {
      opcode_type  opcode;
      logic [11:0] reg_offset;
      logic [31:0] write_data;
      logic [7:0]  rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        push_accepted;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        irq_level;
   } rsp_item_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] push_byte;
   } fifo_cmd_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic       rise;
      logic       fall;
      logic [7:0] head;
   } fifo_status_type;

endpackage

`default_nettype wire

// File: design/uartrx_fifo.sv
// receive fifo: storage, pointers, level and trigger compare
// depends on uartrx_pkg and the macros header
`default_nettype none
`include "uart_registers_with_rx_fifo_core_macros.svh"

module uartrx_fifo #(
   parameter int RX_DEPTH = uartrx_pkg::RX_DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire uartrx_pkg::fifo_cmd_type    fifo_cmd,
   input  wire logic [2:0]                  trig_sel,
   output uartrx_pkg::fifo_status_type      fifo_status
);
   import uartrx_pkg::*;

   localparam int PTR_W = $clog2(RX_DEPTH);
   localparam int LVL_W = $clog2(RX_DEPTH + 1);
   localparam int T1 = ((RX_DEPTH * 1) / 8 < 1) ? 1 : (RX_DEPTH * 1) / 8;
   localparam int T2 = ((RX_DEPTH * 2) / 8 < 1) ? 1 : (RX_DEPTH * 2) / 8;
   localparam int T4 = ((RX_DEPTH * 4) / 8 < 1) ? 1 : (RX_DEPTH * 4) / 8;
   localparam int T6 = ((RX_DEPTH * 6) / 8 < 1) ? 1 : (RX_DEPTH * 6) / 8;
   localparam int T7 = ((RX_DEPTH * 7) / 8 < 1) ? 1 : (RX_DEPTH * 7) / 8;
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(RX_DEPTH - 1);
   localparam logic [LVL_W-1:0] DEPTH_LVL = LVL_W'(RX_DEPTH);

   logic [7:0]       rx_store [RX_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [7:0]       head_ff;
   logic [LVL_W-1:0] trigger;
   logic             full;
   logic             empty;

   always_comb begin
      case (trig_sel)
         TRIG_SEL_EIGHTH:   trigger = LVL_W'(T1);
         TRIG_SEL_QUARTER:  trigger = LVL_W'(T2);
         TRIG_SEL_HALF:     trigger = LVL_W'(T4);
         TRIG_SEL_3QUARTER: trigger = LVL_W'(T6);
         TRIG_SEL_7EIGHTHS: trigger = LVL_W'(T7);
         default:           trigger = LVL_W'(T4);
      endcase
   end

   assign full  = (level_ff == DEPTH_LVL);
   assign empty = (level_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (fifo_cmd.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         level_in  = level_ff + 1'b1;
      end
      if (fifo_cmd.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         level_in  = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage with registered read of the next head, write bypass
   always_ff @(posedge clock) begin
      if (fifo_cmd.push) begin
         rx_store[wr_ptr_ff] <= fifo_cmd.push_byte;
      end
      if (fifo_cmd.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= fifo_cmd.push_byte;
      end else begin
         head_ff <= rx_store[rd_ptr_in];
      end
   end

   always_comb begin
      fifo_status.empty = empty;
      fifo_status.full  = full;
      fifo_status.rise  = (level_ff >= trigger - 1'b1);
      fifo_status.fall  = (level_ff <= trigger);
      fifo_status.head  = head_ff;
   end

   `UARTRX_ASSERT_NOW(a_no_push_full, fifo_cmd.push, !full, "push into full fifo")
   `UARTRX_ASSERT_NOW(a_no_pop_empty, fifo_cmd.pop, !empty, "pop from empty fifo")
   `UARTRX_ASSERT_NEXT(a_push_level, fifo_cmd.push && !fifo_cmd.pop, level_ff == $past(level_ff) + 1'b1, "level not advanced by push")
   `UARTRX_ASSERT_NOW(a_level_bound, 1'b1, level_ff <= DEPTH_LVL, "fifo level above depth")

endmodule

`default_nettype wire

// File: design/uartrx_regs.sv
// register file, bus decode and interrupt logic
// depends on uartrx_pkg
`default_nettype none

module uartrx_regs (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        fire,
   input  wire uartrx_pkg::req_item_type    item,
   input  wire uartrx_pkg::fifo_status_type fifo_status,
   output uartrx_pkg::fifo_cmd_type         fifo_cmd,
   output logic [2:0]                       trig_sel,
   output uartrx_pkg::rsp_item_type         result
);
   import uartrx_pkg::*;

   logic [15:0] baud_int_ff, baud_int_in;
   logic [5:0]  baud_frc_ff, baud_frc_in;
   logic [7:0]  line_ctl_ff, line_ctl_in;
   logic [15:0] control_ff, control_in;
   logic [5:0]  fifo_lvl_ff, fifo_lvl_in;
   logic [10:0] irq_mask_ff, irq_mask_in;
   logic [10:0] irq_raw_ff, irq_raw_in;
   logic [2:0]  dma_ctl_ff, dma_ctl_in;
   logic [31:0] rd_value;
   logic        is_read;
   logic        is_write;
   logic        is_push;

   assign is_read  = fire && (item.opcode == OP_READ);
   assign is_write = fire && (item.opcode == OP_WRITE);
   assign is_push  = fire && (item.opcode == OP_PUSH);
   assign trig_sel = fifo_lvl_ff[5:3];

   always_comb begin
      fifo_cmd.push      = is_push && !fifo_status.full;
      fifo_cmd.pop       = is_read && (item.reg_offset == OFFS_DATA) && !fifo_status.empty;
      fifo_cmd.push_byte = item.rx_byte;
   end

   // read mux
   always_comb begin
      case (item.reg_offset)
         OFFS_DATA:       rd_value = fifo_status.empty ? 32'd0 : {24'd0, fifo_status.head};
         OFFS_RX_STAT:    rd_value = 32'd0;
         OFFS_FLAGS:      rd_value = {24'd0, 1'b1, fifo_status.full, 1'b0,
                                      fifo_status.empty, 4'd0};
         OFFS_BAUD_INT:   rd_value = {16'd0, baud_int_ff};
         OFFS_BAUD_FRC:   rd_value = {26'd0, baud_frc_ff};
         OFFS_LINE_CTL:   rd_value = {24'd0, line_ctl_ff};
         OFFS_CONTROL:    rd_value = {16'd0, control_ff};
         OFFS_FIFO_LVL:   rd_value = {26'd0, fifo_lvl_ff};
         OFFS_IRQ_MASK:   rd_value = {21'd0, irq_mask_ff};
         OFFS_IRQ_RAW:    rd_value = {21'd0, irq_raw_ff};
         OFFS_IRQ_MSKD:   rd_value = {21'd0, irq_raw_ff & irq_mask_ff};
         OFFS_DMA_CTL:    rd_value = {29'd0, dma_ctl_ff};
         OFFS_PERIPH_ID0: rd_value = PERIPH_ID0;
         OFFS_PERIPH_ID1: rd_value = PERIPH_ID1;
         OFFS_PERIPH_ID2: rd_value = PERIPH_ID2;
         OFFS_PERIPH_ID3: rd_value = PERIPH_ID3;
         OFFS_CELL_ID0:   rd_value = CELL_ID0;
         OFFS_CELL_ID1:   rd_value = CELL_ID1;
         OFFS_CELL_ID2:   rd_value = CELL_ID2;
         OFFS_CELL_ID3:   rd_value = CELL_ID3;
         default:         rd_value = 32'd0;
      endcase
   end

   // register updates
   always_comb begin
      baud_int_in = baud_int_ff;
      baud_frc_in = baud_frc_ff;
      line_ctl_in = line_ctl_ff;
      control_in  = control_ff;
      fifo_lvl_in = fifo_lvl_ff;
      irq_mask_in = irq_mask_ff;
      irq_raw_in  = irq_raw_ff;
      dma_ctl_in  = dma_ctl_ff;
      if (is_write) begin
         case (item.reg_offset)
            OFFS_BAUD_INT: baud_int_in = item.write_data[15:0];
            OFFS_BAUD_FRC: baud_frc_in = item.write_data[5:0];
            OFFS_LINE_CTL: line_ctl_in = item.write_data[7:0];
            OFFS_CONTROL: begin
               control_in = item.write_data[15:0];
               if (item.write_data[CTRL_EN_BIT]) begin
                  irq_raw_in[IRQ_TX_BIT] = 1'b1;
               end
            end
            OFFS_FIFO_LVL: fifo_lvl_in = item.write_data[5:0];
            OFFS_IRQ_MASK: irq_mask_in = item.write_data[10:0];
            OFFS_IRQ_CLR:  irq_raw_in  = irq_raw_ff & ~item.write_data[10:0];
            OFFS_DMA_CTL:  dma_ctl_in  = item.write_data[2:0];
            default:       irq_raw_in  = irq_raw_ff;
         endcase
      end
      if (fifo_cmd.push && fifo_status.rise) begin
         irq_raw_in[IRQ_RX_BIT] = 1'b1;
      end
      if (fifo_cmd.pop && fifo_status.fall) begin
         irq_raw_in[IRQ_RX_BIT] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baud_int_ff <= '0;
         baud_frc_ff <= '0;
         line_ctl_ff <= '0;
         control_ff  <= '0;
         fifo_lvl_ff <= FIFO_LVL_RESET;
         irq_mask_ff <= '0;
         irq_raw_ff  <= '0;
         dma_ctl_ff  <= '0;
      end else begin
         baud_int_ff <= baud_int_in;
         baud_frc_ff <= baud_frc_in;
         line_ctl_ff <= line_ctl_in;
         control_ff  <= control_in;
         fifo_lvl_ff <= fifo_lvl_in;
         irq_mask_ff <= irq_mask_in;
         irq_raw_ff  <= irq_raw_in;
         dma_ctl_ff  <= dma_ctl_in;
      end
   end

   always_comb begin
      result.read_data     = (item.opcode == OP_READ) ? rd_value : 32'd0;
      result.push_accepted = (item.opcode == OP_PUSH) && !fifo_status.full;
      result.tx_valid      = (item.opcode == OP_WRITE) && (item.reg_offset == OFFS_DATA)
                             && control_ff[CTRL_TXE_BIT];
      result.tx_byte       = result.tx_valid ? item.write_data[7:0] : 8'd0;
      result.irq_level     = |(irq_raw_in & irq_mask_in);
   end

endmodule

`default_nettype wire

// File: design/uart_registers_with_rx_fifo_core.sv
// uart register block with receive fifo, top level
// one request channel in, one result channel out
// requests: tuser carries the kind (read, write, push received byte), tdata the
//    register offset, the write value and the received byte
// every accepted request yields exactly one result: the read value, whether a
//    pushed byte was stored, a transmit byte with its valid flag, and the
//    interrupt level after the request
// an accepted request is held in the input register; its result is then captured in
//    the result register and held there until taken
// throughput: one request per cycle while the result side takes its results;
//    the input register and the result register are the only pipeline stages
// a stalled result side holds the result; one more request may then sit in
//    the input register before req_tready drops
// reset: synchronous, clears pointers, level, all control registers (fifo level
//    select to its default) and both channel valids; fifo contents are not cleared
// depends on uartrx_pkg, uartrx_fifo, uartrx_regs and the macros header
`default_nettype none
`include "uart_registers_with_rx_fifo_core_macros.svh"

module uart_registers_with_rx_fifo_core #(
   parameter int RX_DEPTH = uartrx_pkg::RX_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // reg_offset, write_data, rx_byte, zero pad
   input  wire logic [1:0]  req_tuser,   // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // read_data, push_accepted, tx_valid, tx_byte,
                                         // irq_level, zero pad
);
   import uartrx_pkg::*;

   req_item_type    in_ff, in_in;
   logic            in_valid_ff, in_valid_in;
   rsp_item_type    rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            advance;
   logic            fire;
   logic            req_accept;
   fifo_cmd_type    fifo_cmd;
   fifo_status_type fifo_status;
   logic [2:0]      trig_sel;
   rsp_item_type    result;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_in.opcode     = opcode_type'(req_tuser);
      in_in.reg_offset = req_tdata[11:0];
      in_in.write_data = req_tdata[43:12];
      in_in.rx_byte    = req_tdata[51:44];
      in_valid_in      = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      rsp_in           = result;
      rsp_valid_in     = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= in_in;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   uartrx_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (in_ff),
      .fifo_status (fifo_status),
      .fifo_cmd    (fifo_cmd),
      .trig_sel    (trig_sel),
      .result      (result)
   );

   uartrx_fifo #(
      .RX_DEPTH (RX_DEPTH)
   ) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .fifo_cmd    (fifo_cmd),
      .trig_sel    (trig_sel),
      .fifo_status (fifo_status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.irq_level, rsp_ff.tx_byte, rsp_ff.tx_valid,
                        rsp_ff.push_accepted, rsp_ff.read_data};

   `UARTRX_ASSERT_NEXT(a_fire_gives_rsp, fire, rsp_tvalid, "processed request left no result")

endmodule

`default_nettype wire
